// ===== src/assert_macros.svh =====
// Assertion macros shared by the base64 encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true at a clock edge outside reset.
`define B64E_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// Antecedent true implies consequent true in the same cycle.
`define B64E_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/b64e_pkg.sv =====
// Types, constants and the symbol table function for the base64 encoder.
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] LAST_IDX = 2'd3;
   localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } rsp_type;

   // One group of up to three bytes, missing bytes already zero.
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  len;
      logic        fin;
   } group_type;

   // Map a sextet onto the standard alphabet.
   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = w + 8'd65;         // 'A'..'Z'
      end else if (v < 6'd52) begin
         c = w + 8'd71;         // 'a'..'z'
      end else if (v < 6'd62) begin
         c = w - 8'd4;          // '0'..'9'
      end else if (v == 6'd62) begin
         c = 8'h2b;             // '+'
      end else begin
         c = 8'h2f;             // '/'
      end
      return c;
   endfunction

endpackage

// ===== src/b64e_front.sv =====
// Front end: takes bytes, holds partial groups and forms full groups or a short last group.
`include "assert_macros.svh"

module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  b64e_pkg::req_type   req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output b64e_pkg::group_type push_data
);

   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  cnt_eff;
   logic        accept;
   logic        hold;
   logic [7:0]  b;

   assign b         = req_data.data_byte;
   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign cnt_eff   = (cnt_ff == 2'd3) ? 2'd2 : cnt_ff;
   assign hold      = (cnt_eff != 2'd2) && !req_data.end_of_message;
   assign push_valid = accept && !hold;

   always_comb begin
      push_data.fin = req_data.end_of_message;
      unique case (cnt_eff)
         2'd0: begin
            push_data.bytes = {b, 16'h0000};
            push_data.len   = 2'd1;
         end
         2'd1: begin
            push_data.bytes = {held_ff[15:8], b, 8'h00};
            push_data.len   = 2'd2;
         end
         default: begin
            push_data.bytes = {held_ff, b};
            push_data.len   = 2'd3;
         end
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      held_in = held_ff;
      if (accept) begin
         if (hold) begin
            cnt_in  = cnt_eff + 2'd1;
            held_in = (cnt_eff == 2'd0) ? {b, 8'h00} : {held_ff[15:8], b};
         end else begin
            cnt_in  = 2'd0;
            held_in = 16'h0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         held_ff <= 16'h0000;
      end else begin
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

   `B64E_NEVER(a_cnt_three, cnt_ff == 2'd3, "front: held count reached three")

endmodule

// ===== src/b64e_queue.sv =====
// Short group queue between front and back ends.
`include "assert_macros.svh"

module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  b64e_pkg::group_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output b64e_pkg::group_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   b64e_pkg::group_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;
   logic             push;
   logic             pop;

   assign full       = (count_ff == CNT_FULL);
   assign push_ready = !full;
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !full;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `B64E_NEVER(a_push_full, push_valid && full, "queue: push while full")
   `B64E_NEVER(a_count_range, count_ff > CNT_FULL, "queue: count beyond depth")

endmodule

// ===== src/b64e_back.sv =====
// Back end: expands each group into four characters, one per cycle unless rsp_ready stalls.
`include "assert_macros.svh"

module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  b64e_pkg::group_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output b64e_pkg::rsp_type   rsp_data
);

   logic                busy_ff, busy_in;
   logic [1:0]          idx_ff, idx_in;
   b64e_pkg::group_type grp_ff, grp_in;
   logic                out_valid_ff, out_valid_in;
   b64e_pkg::rsp_type   out_ff, out_in;
   b64e_pkg::rsp_type   next_char;
   logic                load;
   logic [7:0]          b0, b1, b2;

   assign b0 = grp_ff.bytes[23:16];
   assign b1 = grp_ff.bytes[15:8];
   assign b2 = grp_ff.bytes[7:0];

   assign load      = busy_ff && (!out_valid_ff || rsp_ready);
   assign pop_ready = !busy_ff || (load && (idx_ff == b64e_pkg::LAST_IDX));
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      next_char.last_char = grp_ff.fin && (idx_ff == b64e_pkg::LAST_IDX);
      unique case (idx_ff)
         2'd0: next_char.text_char = b64e_pkg::sym(b0[7:2]);
         2'd1: next_char.text_char = b64e_pkg::sym({b0[1:0], b1[7:4]});
         2'd2: next_char.text_char = (grp_ff.len < 2'd2) ? b64e_pkg::PAD_CHAR
                                      : b64e_pkg::sym({b1[3:0], b2[7:6]});
         default: next_char.text_char = (grp_ff.len < 2'd3) ? b64e_pkg::PAD_CHAR
                                         : b64e_pkg::sym(b2[5:0]);
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      grp_in       = grp_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         idx_in       = idx_ff + 2'd1;
         out_valid_in = 1'b1;
         out_in       = next_char;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (pop_ready) begin
         busy_in = pop_valid;
         grp_in  = pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      out_ff <= out_in;
   end

   `B64E_IMPLY(a_idx_busy, idx_ff != 2'd0, busy_ff, "back: mid-group index while idle")

endmodule

// ===== src/base64_stream_encoder_top.sv =====
// Top level of the streaming base64 encoder.
//
//   channel | direction | payload                      | transfer when
//   --------+-----------+------------------------------+------------------------
//   req_    | in        | data_byte, end_of_message    | req_valid & req_ready
//   rsp_    | out       | text_char, last_char         | rsp_valid & rsp_ready
//
// Rates: one byte is taken per cycle while the group queue has room; each
//   group leaves as four characters, one per cycle while rsp_ready is high,
//   so full groups are paced by the single character output register.
// Path: the transfer that closes a group passes the queue write, the group
//   register and the output register before its first character.
// Reset: synchronous; clears held count, queue pointers and output valid.
// Stalls: rsp_ready low holds the current character; the queue then fills
//   and req_ready drops until the back end frees a slot.
module base64_stream_encoder_top #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64e_pkg::rsp_type rsp_data
);

   // group hand-off between the ends
   logic                push_valid;
   logic                push_ready;
   b64e_pkg::group_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   b64e_pkg::group_type pop_data;

   // front end: packs bytes into groups of up to three, zero-filled
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples byte intake from character output
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back end: sextet split, alphabet lookup and '=' padding
   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
